// File: hw/rtl/e2c_pkg.sv
// Types and constants for the epoch to calendar time converter.
// No dependencies; used by the top level.
package e2c_pkg;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_DIV   = 6'b000010,
        S_FIX   = 6'b000100,
        S_YEAR  = 6'b001000,
        S_MONTH = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    typedef enum logic [3:0] {
        PH_DAY  = 4'b0001,
        PH_HOUR = 4'b0010,
        PH_MIN  = 4'b0100,
        PH_QUAD = 4'b1000
    } phase_t;

    localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
    localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
    localparam logic [16:0] SECS_PER_MIN  = 17'd60;
    localparam logic [16:0] DAYS_PER_QUAD = 17'd1461;
    localparam logic [16:0] DAYS_TO_2100_MAR = 17'd47541;
    localparam logic [16:0] DAYS_PER_YEAR = 17'd365;
    localparam logic [7:0]  BASE_YEAR_OFS = 8'd70;
    localparam logic [1:0]  LEAP_SLOT     = 2'd2;
    localparam logic [3:0]  MONTH_FEB     = 4'd1;
    localparam logic [3:0]  MONTH_DEC     = 4'd11;

    function automatic logic [4:0] days_in_month(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m)
            4'd0:    len = 5'd31;
            4'd1:    len = 5'd28;
            4'd2:    len = 5'd31;
            4'd3:    len = 5'd30;
            4'd4:    len = 5'd31;
            4'd5:    len = 5'd30;
            4'd6:    len = 5'd31;
            4'd7:    len = 5'd31;
            4'd8:    len = 5'd30;
            4'd9:    len = 5'd31;
            4'd10:   len = 5'd30;
            4'd11:   len = 5'd31;
            default: len = 5'd31;
        endcase
        if (leap && (m == MONTH_FEB))
        begin
            len = len + 5'd1;
        end
        return len;
    endfunction

endpackage

// File: hw/rtl/e2c_in_if.sv
// Input channel: one epoch word per handshake.
// No dependencies.
interface e2c_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] epoch_seconds;

    modport source (output valid, output epoch_seconds, input ready);
    modport sink   (input valid, input epoch_seconds, output ready);
endinterface

// File: hw/rtl/e2c_out_if.sv
// Output channel: one calendar time word per handshake.
// No dependencies.
interface e2c_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] years_since_1900;
    logic [3:0] month_number;
    logic [4:0] day_of_month;
    logic [4:0] hour_of_day;
    logic [5:0] minute_of_hour;
    logic [5:0] second_of_minute;

    modport source (output valid, output years_since_1900, output month_number,
                    output day_of_month, output hour_of_day, output minute_of_hour,
                    output second_of_minute, input ready);
    modport sink   (input valid, input years_since_1900, input month_number,
                    input day_of_month, input hour_of_day, input minute_of_hour,
                    input second_of_minute, output ready);
endinterface

// File: hw/rtl/e2c_cfg_if.sv
// Configuration write channel: one time-zone offset word per handshake.
// No dependencies.
interface e2c_cfg_if;
    logic               valid;
    logic               ready;
    logic signed [16:0] utc_offset_seconds;

    modport source (output valid, output utc_offset_seconds, input ready);
    modport sink   (input valid, input utc_offset_seconds, output ready);
endinterface

// File: hw/rtl/epoch_to_calendar_time_unit.sv
// Epoch seconds to Gregorian calendar time, with saturating time-zone offset.
// Depends on e2c_pkg, e2c_in_if, e2c_out_if, e2c_cfg_if.
// Sequencing: one shared 18-bit compare/subtract unit serves the steps from input accept to
// output valid: 33 restoring divide steps, 1 to 4 year steps, 1 to 12 month steps.
// A new epoch word is taken only in idle, after the last is loaded out; a held output word stalls the load of the next.
// Reset: asynchronous active low; clears the sequencer, output valid and the offset.
module epoch_to_calendar_time_unit (
    input  logic       clk,
    input  logic       rst_n,
    e2c_in_if.sink     epoch,
    e2c_out_if.source  cal,
    e2c_cfg_if.sink    cfg
);

    e2c_pkg::state_t    state_reg, state_next;
    e2c_pkg::phase_t    phase_reg, phase_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic [16:0]        rem_reg, rem_next;
    logic [31:0]        num_reg, num_next;
    logic [15:0]        days_reg, days_next;
    logic [4:0]         hour_reg, hour_next;
    logic [5:0]         min_reg, min_next;
    logic [5:0]         sec_reg, sec_next;
    logic [1:0]         k_reg, k_next;
    logic [3:0]         mon_reg, mon_next;
    logic signed [16:0] offset_reg;
    logic               out_valid_reg, out_valid_next;
    logic               out_load;
    logic [7:0]         year_out_reg;
    logic [3:0]         mon_out_reg;
    logic [4:0]         day_out_reg;
    logic [4:0]         hour_out_reg;
    logic [5:0]         min_out_reg;
    logic [5:0]         sec_out_reg;

    logic [17:0]        unit_a;
    logic [16:0]        unit_b;
    logic [17:0]        unit_diff;
    logic               unit_borrow;
    logic               unit_ge;
    logic [17:0]        trial;
    logic [16:0]        divisor;
    logic signed [33:0] sum;
    logic [31:0]        sat;
    logic [15:0]        days_fixed;

    assign epoch.ready = (state_reg == e2c_pkg::S_IDLE);
    assign cfg.ready   = 1'b1;

    assign cal.valid            = out_valid_reg;
    assign cal.years_since_1900 = year_out_reg;
    assign cal.month_number     = mon_out_reg;
    assign cal.day_of_month     = day_out_reg;
    assign cal.hour_of_day      = hour_out_reg;
    assign cal.minute_of_hour   = min_out_reg;
    assign cal.second_of_minute = sec_out_reg;

    // saturate the local time to the unsigned 32-bit range
    always_comb
    begin
        sum = $signed({2'b00, epoch.epoch_seconds}) + 34'(offset_reg);
        if (sum[33])
        begin
            sat = '0;
        end
        else if (sum[32])
        begin
            sat = '1;
        end
        else
        begin
            sat = sum[31:0];
        end
    end

    always_comb
    begin
        case (phase_reg)
            e2c_pkg::PH_DAY:  divisor = e2c_pkg::SECS_PER_DAY;
            e2c_pkg::PH_HOUR: divisor = e2c_pkg::SECS_PER_HOUR;
            e2c_pkg::PH_MIN:  divisor = e2c_pkg::SECS_PER_MIN;
            e2c_pkg::PH_QUAD: divisor = e2c_pkg::DAYS_PER_QUAD;
            default:          divisor = e2c_pkg::SECS_PER_DAY;
        endcase
    end

    assign trial = {rem_reg, num_reg[31]};

    // shared compare/subtract unit
    always_comb
    begin
        case (state_reg)
            e2c_pkg::S_DIV:
            begin
                unit_a = trial;
                unit_b = divisor;
            end
            e2c_pkg::S_FIX:
            begin
                unit_a = {2'b00, days_reg};
                unit_b = e2c_pkg::DAYS_TO_2100_MAR;
            end
            e2c_pkg::S_YEAR:
            begin
                unit_a = {1'b0, rem_reg};
                unit_b = (k_reg == e2c_pkg::LEAP_SLOT) ? e2c_pkg::DAYS_PER_YEAR + 17'd1
                                                       : e2c_pkg::DAYS_PER_YEAR;
            end
            e2c_pkg::S_MONTH:
            begin
                unit_a = {1'b0, rem_reg};
                unit_b = {12'd0, e2c_pkg::days_in_month(mon_reg, k_reg == e2c_pkg::LEAP_SLOT)};
            end
            default:
            begin
                unit_a = '0;
                unit_b = '0;
            end
        endcase
        {unit_borrow, unit_diff} = {1'b0, unit_a} - {2'b00, unit_b};
        unit_ge = ~unit_borrow;
    end

    // skip the missing leap day of 2100 so a plain four-year cycle holds
    assign days_fixed = unit_ge ? days_reg + 16'd1 : days_reg;

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        num_next   = num_reg;
        days_next  = days_reg;
        hour_next  = hour_reg;
        min_next   = min_reg;
        sec_next   = sec_reg;
        k_next     = k_reg;
        mon_next   = mon_reg;
        out_load   = 1'b0;

        case (state_reg)
            e2c_pkg::S_IDLE:
            begin
                if (epoch.valid)
                begin
                    rem_next   = {1'b0, sat[31:16]};
                    num_next   = {sat[15:0], 16'd0};
                    cnt_next   = 5'd15;
                    phase_next = e2c_pkg::PH_DAY;
                    state_next = e2c_pkg::S_DIV;
                end
            end
            e2c_pkg::S_DIV:
            begin
                rem_next = unit_ge ? unit_diff[16:0] : trial[16:0];
                num_next = {num_reg[30:0], unit_ge};
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                begin
                    case (phase_reg)
                        e2c_pkg::PH_DAY:
                        begin
                            days_next  = num_next[15:0];
                            num_next   = {rem_next[4:0], 27'd0};
                            rem_next   = {5'd0, rem_next[16:5]};
                            cnt_next   = 5'd4;
                            phase_next = e2c_pkg::PH_HOUR;
                        end
                        e2c_pkg::PH_HOUR:
                        begin
                            hour_next  = num_next[4:0];
                            num_next   = {rem_next[5:0], 26'd0};
                            rem_next   = {11'd0, rem_next[11:6]};
                            cnt_next   = 5'd5;
                            phase_next = e2c_pkg::PH_MIN;
                        end
                        e2c_pkg::PH_MIN:
                        begin
                            min_next   = num_next[5:0];
                            sec_next   = rem_next[5:0];
                            state_next = e2c_pkg::S_FIX;
                        end
                        e2c_pkg::PH_QUAD:
                        begin
                            k_next     = 2'd0;
                            state_next = e2c_pkg::S_YEAR;
                        end
                        default:
                        begin
                            state_next = e2c_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            e2c_pkg::S_FIX:
            begin
                rem_next   = {7'd0, days_fixed[15:6]};
                num_next   = {days_fixed[5:0], 26'd0};
                cnt_next   = 5'd5;
                phase_next = e2c_pkg::PH_QUAD;
                state_next = e2c_pkg::S_DIV;
            end
            e2c_pkg::S_YEAR:
            begin
                if (unit_ge)
                begin
                    rem_next = unit_diff[16:0];
                    k_next   = k_reg + 2'd1;
                end
                else
                begin
                    mon_next   = 4'd0;
                    state_next = e2c_pkg::S_MONTH;
                end
            end
            e2c_pkg::S_MONTH:
            begin
                if (unit_ge && (mon_reg != e2c_pkg::MONTH_DEC))
                begin
                    rem_next = unit_diff[16:0];
                    mon_next = mon_reg + 4'd1;
                end
                else
                begin
                    state_next = e2c_pkg::S_DONE;
                end
            end
            e2c_pkg::S_DONE:
            begin
                if (!out_valid_reg || cal.ready)
                begin
                    out_load   = 1'b1;
                    state_next = e2c_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = e2c_pkg::S_IDLE;
            end
        endcase
    end

    assign out_valid_next = (out_valid_reg & ~cal.ready) | out_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= e2c_pkg::S_IDLE;
            phase_reg     <= e2c_pkg::PH_DAY;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            offset_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
            begin
                offset_reg <= cfg.utc_offset_seconds;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        num_reg  <= num_next;
        days_reg <= days_next;
        hour_reg <= hour_next;
        min_reg  <= min_next;
        sec_reg  <= sec_next;
        k_reg    <= k_next;
        mon_reg  <= mon_next;
        if (out_load)
        begin
            year_out_reg <= e2c_pkg::BASE_YEAR_OFS + {num_reg[5:0], 2'b00} + {6'd0, k_reg};
            mon_out_reg  <= mon_reg + 4'd1;
            day_out_reg  <= rem_reg[4:0] + 5'd1;
            hour_out_reg <= hour_reg;
            min_out_reg  <= min_reg;
            sec_out_reg  <= sec_reg;
        end
    end

endmodule

// File: hw/rtl/e2c_check.sv
// Port-level checks for the epoch to calendar time converter.
// Depends on epoch_to_calendar_time_unit; attached by the bind below.
module e2c_check (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] years,
    input logic [3:0] month,
    input logic [4:0] day,
    input logic [4:0] hour,
    input logic [5:0] minute,
    input logic [5:0] second
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(years) && $stable(day))
        else $error("stalled output word changed");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while a word is in conversion");

    a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (month >= 4'd1) && (month <= 4'd12) && (day >= 5'd1)
                      && (years >= 8'd70) && (years <= 8'd206))
        else $error("date field out of range");

    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (hour < 5'd24) && (minute < 6'd60) && (second < 6'd60))
        else $error("time field out of range");

endmodule

bind epoch_to_calendar_time_unit e2c_check u_e2c_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (epoch.valid),
    .in_ready  (epoch.ready),
    .out_valid (cal.valid),
    .out_ready (cal.ready),
    .years     (cal.years_since_1900),
    .month     (cal.month_number),
    .day       (cal.day_of_month),
    .hour      (cal.hour_of_day),
    .minute    (cal.minute_of_hour),
    .second    (cal.second_of_minute)
);

// File: sim/e2c_cal_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the epoch to calendar time converter: predicts each calendar word from
// the accepted epoch word and the current time-zone offset, and checks the output channel.
// Depends on the interfaces e2c_in_if, e2c_out_if and e2c_cfg_if.
module e2c_cal_checker (
    input  logic clk,
    input  logic rst_n,
    input  logic run_end,
    e2c_in_if    epoch,
    e2c_out_if   cal,
    e2c_cfg_if   cfg,
    output int   failures,
    output int   pending
);

    typedef struct packed {
        logic [7:0] years_since_1900;
        logic [3:0] month_number;
        logic [4:0] day_of_month;
        logic [4:0] hour_of_day;
        logic [5:0] minute_of_hour;
        logic [5:0] second_of_minute;
    } cal_word_t;

    // Index 0 is January.
    localparam logic [11:0][4:0] MONTH_LEN = {5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31,
                                              5'd30, 5'd31, 5'd30, 5'd31, 5'd28, 5'd31};
    localparam longint TIME_MAX    = 64'h0000_0000_FFFF_FFFF;

    logic signed [16:0] tz_offset;
    cal_word_t          cal_expect_q [$];
    bit                 end_checked;

    initial
    begin
        failures    = 0;
        pending     = 0;
        end_checked = 1'b0;
    end

    function automatic bit is_leap(input int unsigned yr);
        return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
    endfunction

    function automatic cal_word_t calendar_of(input logic [31:0] e,
                                              input logic signed [16:0] ofs);
        cal_word_t   w;
        longint      adj;
        int unsigned s;
        int unsigned days;
        int unsigned yr;
        int unsigned mon;
        int unsigned mlen;
        adj = longint'({32'd0, e}) + longint'(ofs);
        if (adj < 0)
        begin
            adj = 0;
        end
        else if (adj > TIME_MAX)
        begin
            adj = TIME_MAX;
        end
        s = adj[31:0];
        w.second_of_minute = 6'(s % 60);
        s = s / 60;
        w.minute_of_hour = 6'(s % 60);
        s = s / 60;
        w.hour_of_day = 5'(s % 24);
        days = s / 24;
        yr = 1970;
        while (days >= (is_leap(yr) ? 366 : 365))
        begin
            days = days - (is_leap(yr) ? 366 : 365);
            yr++;
        end
        mon = 0;
        while (mon < 11)
        begin
            mlen = MONTH_LEN[mon] + ((mon == 1 && is_leap(yr)) ? 1 : 0);
            if (days < mlen)
            begin
                break;
            end
            days = days - mlen;
            mon++;
        end
        w.years_since_1900 = 8'(yr - 1900);
        w.month_number     = 4'(mon + 1);
        w.day_of_month     = 5'(days + 1);
        return w;
    endfunction

    task automatic log_mismatch(input string what, input int got, input int want);
        $display("%0t ns: %s: got %0d, want %0d", $time, what, got, want);
        failures++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        cal_word_t got;
        cal_word_t want;
        if (!rst_n)
        begin
            tz_offset = '0;
            pending <= 0;
        end
        else
        begin
            if (cal.valid && cal.ready)
            begin
                got = {cal.years_since_1900, cal.month_number, cal.day_of_month,
                       cal.hour_of_day, cal.minute_of_hour, cal.second_of_minute};
                if (cal_expect_q.size() == 0)
                begin
                    log_mismatch("calendar word with none expected, year",
                                 got.years_since_1900, -1);
                end
                else
                begin
                    want = cal_expect_q.pop_front();
                    if (got.years_since_1900 != want.years_since_1900)
                        log_mismatch("years_since_1900", got.years_since_1900, want.years_since_1900);
                    if (got.month_number != want.month_number)
                        log_mismatch("month_number", got.month_number, want.month_number);
                    if (got.day_of_month != want.day_of_month)
                        log_mismatch("day_of_month", got.day_of_month, want.day_of_month);
                    if (got.hour_of_day != want.hour_of_day)
                        log_mismatch("hour_of_day", got.hour_of_day, want.hour_of_day);
                    if (got.minute_of_hour != want.minute_of_hour)
                        log_mismatch("minute_of_hour", got.minute_of_hour, want.minute_of_hour);
                    if (got.second_of_minute != want.second_of_minute)
                        log_mismatch("second_of_minute", got.second_of_minute, want.second_of_minute);
                end
            end
            if (epoch.valid && epoch.ready)
            begin
                cal_expect_q.push_back(calendar_of(epoch.epoch_seconds, tz_offset));
            end
            if (cfg.valid && cfg.ready)
            begin
                tz_offset = cfg.utc_offset_seconds;
            end
            if (run_end && !end_checked)
            begin
                end_checked = 1'b1;
                foreach (cal_expect_q[i])
                begin
                    log_mismatch("calendar word never delivered, year", -1,
                                 cal_expect_q[i].years_since_1900);
                end
            end
            pending <= cal_expect_q.size();
        end
    end

endmodule

// File: sim/tb_epoch_to_calendar_time_unit.sv
`timescale 1ns / 1ps
// Testbench top for epoch_to_calendar_time_unit: drives epoch words and offset writes
// with random idling and gives the verdict; checking lives in e2c_cal_checker.
// Depends on the RTL interfaces, the converter and e2c_cal_checker.
module tb_epoch_to_calendar_time_unit;

    localparam int SETTLE_CYCLES   = 64;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int RANDOM_PHASES   = 9;
    localparam int WORDS_PER_PHASE = 137;

    logic clk = 1'b0;
    logic rst_n;
    logic run_end;
    int   failures;
    int   pending;
    int   src_idle_pct;
    int   snk_idle_pct;
    int   stall_cycles = 0;

    logic signed [16:0] tz_plan [0:RANDOM_PHASES-1];

    // Day, month and year boundaries, leap days and the 31-bit edge.
    logic [31:0] calendar_edges [0:15] = '{
        32'd0, 32'd59, 32'd60, 32'd3599, 32'd86399,
        32'd68169600, 32'd68256000, 32'd94608000, 32'd94694399,
        32'd951782400, 32'd978220800, 32'd978307200,
        32'd2147483647, 32'd2147483648, 32'd4107542399, 32'hFFFF_FFFF
    };

    e2c_in_if  epoch_ch ();
    e2c_out_if cal_ch ();
    e2c_cfg_if cfg_ch ();

    epoch_to_calendar_time_unit u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .epoch (epoch_ch),
        .cal   (cal_ch),
        .cfg   (cfg_ch)
    );

    e2c_cal_checker u_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .run_end  (run_end),
        .epoch    (epoch_ch),
        .cal      (cal_ch),
        .cfg      (cfg_ch),
        .failures (failures),
        .pending  (pending)
    );

    always #2 clk = ~clk;

    function automatic logic [31:0] pick_epoch();
        logic [31:0] e;
        case ($urandom_range(0, 9))
            6:       e = $urandom_range(0, 100000);
            7:       e = 32'hFFFF_FFFF - $urandom_range(0, 100000);
            8:       e = $urandom_range(0, 49710) * 32'd86400 - $urandom_range(0, 1);
            default: e = $urandom();
        endcase
        return e;
    endfunction

    task automatic send_epoch(input logic [31:0] e);
        if (src_idle_pct > 0 && $urandom_range(1, 100) <= src_idle_pct)
        begin
            epoch_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        epoch_ch.valid         <= 1'b1;
        epoch_ch.epoch_seconds <= e;
        @(posedge clk);
        while (!epoch_ch.ready)
        begin
            @(posedge clk);
        end
    endtask

    // Hold the sender until every calendar word is back and the unit is idle.
    task automatic drain();
        epoch_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_offset(input logic signed [16:0] ofs);
        drain();
        cfg_ch.valid              <= 1'b1;
        cfg_ch.utc_offset_seconds <= ofs;
        @(posedge clk);
        while (!cfg_ch.ready)
        begin
            @(posedge clk);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    initial
    begin
        cal_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && snk_idle_pct > 0 && $urandom_range(1, 100) <= snk_idle_pct)
            begin
                cal_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
            cal_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (epoch_ch.valid && epoch_ch.ready) || (cal_ch.valid && cal_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles == WATCHDOG_LIMIT)
        begin
            $display("epoch_to_calendar_time_unit verification failed");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        rst_n                     = 1'b0;
        run_end                   = 1'b0;
        epoch_ch.valid            = 1'b0;
        epoch_ch.epoch_seconds    = '0;
        cfg_ch.valid              = 1'b0;
        cfg_ch.utc_offset_seconds = '0;
        src_idle_pct              = 30;
        snk_idle_pct              = 30;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (calendar_edges[i])
        begin
            send_epoch(calendar_edges[i]);
        end

        // Negative sums clamp to the epoch start.
        write_offset(-17'sd50400);
        send_epoch(32'd0);
        send_epoch(32'd50399);
        send_epoch(32'd50400);
        send_epoch(32'hFFFF_FFFF);

        // Sums past 32 bits clamp to the last second.
        write_offset(17'sd65535);
        send_epoch(32'hFFFF_FFFF);
        send_epoch(32'hFFFF_0000);
        send_epoch(32'hFFFF_0001);

        write_offset(-17'sd65536);
        send_epoch(32'd65535);
        send_epoch(32'd65536);

        tz_plan[0] = 17'sd50400;
        tz_plan[1] = -17'sd50400;
        tz_plan[2] = 17'sd0;
        for (int p = 3; p < RANDOM_PHASES; p++)
        begin
            tz_plan[p] = 17'(int'($urandom_range(0, 100800)) - 50400);
        end
        tz_plan[7] = 17'($urandom());

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            write_offset(tz_plan[p]);
            if (p == RANDOM_PHASES - 1)
            begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            else
            begin
                src_idle_pct = (p % 3) * 20;
                snk_idle_pct = ((p + 1) % 3) * 20;
            end
            repeat (WORDS_PER_PHASE)
            begin
                send_epoch(pick_epoch());
            end
        end

        drain();
        run_end <= 1'b1;
        repeat (2) @(posedge clk);
        if (failures == 0)
        begin
            $display("epoch_to_calendar_time_unit verification clean");
        end
        else
        begin
            $display("epoch_to_calendar_time_unit verification failed");
        end
        $finish;
    end

endmodule
